// ----- hw/rtl/psf_pkg.sv -----
// Shared types and constants for the prime sieve filter chain.
// Used by prime_sieve_filter_chain_top; depends on nothing.
package psf_pkg;

    localparam int unsigned NUM_STAGES = 32;
    localparam int unsigned VALUE_BITS = 16;

    localparam int unsigned IDX_BITS   = (NUM_STAGES > 1) ? $clog2(NUM_STAGES) : 1;
    localparam int unsigned CNT_BITS   = $clog2(NUM_STAGES + 1);
    localparam int unsigned BIT_BITS   = $clog2(VALUE_BITS);

    typedef struct packed {
        logic [15:0] candidate;
        logic        start_of_run;
    } t_in_item;

    typedef struct packed {
        logic [15:0] prime_value;
        logic [5:0]  prime_index;
        logic        unverified;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_DIV,
        S_DONE
    } t_state;

endpackage

// ----- hw/rtl/psf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the stored primes of the sieve.
module psf_ram #(
    parameter int WIDTH     = 16,
    parameter int DEPTH     = 32,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [ADDR_BITS-1:0] i_waddr,
    input  logic [WIDTH-1:0]     i_wdata,
    input  logic                 i_re,
    input  logic [ADDR_BITS-1:0] i_raddr,
    output logic [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/prime_sieve_filter_chain_top.sv -----
// Top level of the prime sieve filter chain: sequencer, bit-serial remainder unit.
// Depends on psf_pkg and psf_ram.
//
// Usage:
//   Input channel (i_valid / o_stall, payload i_item): one candidate per item.
//   start_of_run empties the prime table; the candidate is then stored untested.
//   Output channel (o_valid / i_stall, payload o_item): one item per candidate
//   that no stored prime divides; divisible candidates give no output item.
//   The candidate is checked against each stored prime in turn by one shared
//   restoring remainder unit, one quotient bit per cycle. Each stage does a
//   table read, a divisor load and VALUE_BITS remainder steps; a stored zero
//   skips the steps. A candidate that a stored prime divides is dropped at
//   that stage, without checking the remaining stored primes.
//   o_stall is high from acceptance until the item is finished.
//   A survivor is stored in the next free stage; with the table full it is
//   sent with unverified set and prime_index equal to NUM_STAGES.
//   The output register holds a finished item while i_stall is high; the next
//   item is accepted and tested meanwhile and waits only to hand over its result.
//   Reset empties the table (count of stored primes zero) and the output.
module prime_sieve_filter_chain_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  psf_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output psf_pkg::t_out_item  o_item
);

    localparam int VB = psf_pkg::VALUE_BITS;
    localparam int CB = psf_pkg::CNT_BITS;
    localparam int IB = psf_pkg::IDX_BITS;
    localparam int BB = psf_pkg::BIT_BITS;

    psf_pkg::t_state r_state, n_state;

    logic [CB-1:0]      r_count, n_count;
    logic [CB-1:0]      r_idx, n_idx;
    logic [BB-1:0]      r_bit, n_bit;
    logic [VB-1:0]      r_cand, n_cand;
    logic [VB-1:0]      r_shift, n_shift;
    logic [VB-1:0]      r_div, n_div;
    logic [VB-1:0]      r_rem, n_rem;
    logic               r_out_valid, n_out_valid;
    psf_pkg::t_out_item r_out, n_out;

    logic               in_accept;
    logic               table_full;
    logic               last_stage;
    logic               out_free;
    logic [VB+15:0]     cand_in_ext;
    logic [VB+15:0]     cand_out_ext;
    logic [CB+5:0]      count_ext;
    logic [VB:0]        partial;
    logic [VB:0]        step_diff;
    logic [VB-1:0]      step_rem;

    logic               ram_we;
    logic               ram_re;
    logic [VB-1:0]      ram_rdata;

    assign in_accept    = i_valid && !o_stall;
    assign table_full   = (r_count == CB'(psf_pkg::NUM_STAGES));
    assign last_stage   = ((r_idx + CB'(1)) == r_count);
    assign out_free     = !r_out_valid || !i_stall;
    assign cand_in_ext  = {VB'(0), i_item.candidate};
    assign cand_out_ext = {16'd0, r_cand};
    assign count_ext    = {6'd0, r_count};

    // One restoring remainder step: shift in the next candidate bit, subtract if it fits.
    assign partial   = {r_rem, r_shift[VB-1]};
    assign step_diff = partial - {1'b0, r_div};
    assign step_rem  = (partial >= {1'b0, r_div}) ? step_diff[VB-1:0] : partial[VB-1:0];

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            psf_pkg::S_IDLE: begin
                if (in_accept) begin
                    if (i_item.start_of_run || (r_count == '0)) begin
                        n_state = psf_pkg::S_DONE;
                    end else begin
                        n_state = psf_pkg::S_READ;
                    end
                end
            end
            psf_pkg::S_READ: begin
                n_state = psf_pkg::S_LOAD;
            end
            psf_pkg::S_LOAD: begin
                if (ram_rdata == '0) begin
                    if (r_cand == '0) begin
                        n_state = psf_pkg::S_IDLE;
                    end else if (last_stage) begin
                        n_state = psf_pkg::S_DONE;
                    end else begin
                        n_state = psf_pkg::S_READ;
                    end
                end else begin
                    n_state = psf_pkg::S_DIV;
                end
            end
            psf_pkg::S_DIV: begin
                if (r_bit == '0) begin
                    if (step_rem == '0) begin
                        n_state = psf_pkg::S_IDLE;
                    end else if (last_stage) begin
                        n_state = psf_pkg::S_DONE;
                    end else begin
                        n_state = psf_pkg::S_READ;
                    end
                end
            end
            psf_pkg::S_DONE: begin
                if (out_free) begin
                    n_state = psf_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = psf_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and datapath
    always_comb begin
        o_stall     = (r_state != psf_pkg::S_IDLE);
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        n_count     = r_count;
        n_idx       = r_idx;
        n_bit       = r_bit;
        n_cand      = r_cand;
        n_shift     = r_shift;
        n_div       = r_div;
        n_rem       = r_rem;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_stall;
        case (r_state)
            psf_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_cand = cand_in_ext[VB-1:0];
                    n_idx  = '0;
                    if (i_item.start_of_run) begin
                        n_count = '0;
                    end
                end
            end
            psf_pkg::S_READ: begin
                ram_re = 1'b1;
            end
            psf_pkg::S_LOAD: begin
                n_div   = ram_rdata;
                n_shift = r_cand;
                n_rem   = '0;
                n_bit   = BB'(VB - 1);
                // a stored zero only drops candidate zero; skip the divide
                if (ram_rdata == '0) begin
                    n_idx = CB'(r_idx + CB'(1));
                end
            end
            psf_pkg::S_DIV: begin
                n_rem   = step_rem;
                n_shift = {r_shift[VB-2:0], 1'b0};
                n_bit   = BB'(r_bit - BB'(1));
                if (r_bit == '0) begin
                    n_idx = CB'(r_idx + CB'(1));
                end
            end
            psf_pkg::S_DONE: begin
                if (out_free) begin
                    n_out_valid       = 1'b1;
                    n_out.prime_value = cand_out_ext[15:0];
                    n_out.prime_index = count_ext[5:0];
                    n_out.unverified  = table_full;
                    if (!table_full) begin
                        ram_we  = 1'b1;
                        n_count = CB'(r_count + CB'(1));
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= psf_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_bit   <= n_bit;
        r_cand  <= n_cand;
        r_shift <= n_shift;
        r_div   <= n_div;
        r_rem   <= n_rem;
        r_out   <= n_out;
    end

    psf_ram #(
        .WIDTH     (VB),
        .DEPTH     (psf_pkg::NUM_STAGES),
        .ADDR_BITS (IB)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[IB-1:0]),
        .i_wdata (r_cand),
        .i_re    (ram_re),
        .i_raddr (r_idx[IB-1:0]),
        .o_rdata (ram_rdata)
    );

    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    a_write_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_count < CB'(psf_pkg::NUM_STAGES)))
        else $error("table written while full");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CB'(psf_pkg::NUM_STAGES))
        else $error("prime count beyond stage count");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> o_stall)
        else $error("input not stalled after accepting an item");

    a_rem_below_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psf_pkg::S_DIV) |-> (r_rem < r_div))
        else $error("partial remainder not below divisor");

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !$past(o_valid)) |-> ($past(r_state) == psf_pkg::S_DONE))
        else $error("output item raised outside the done step");

    a_stage_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == psf_pkg::S_READ) |-> (r_idx < r_count))
        else $error("stage index past the stored primes");

endmodule
